// File: hdl/msdg_pkg.sv
// Package for the multi-axis step/direction generator.
// Holds item kind codes and timing constants; no dependencies.
package msdg_pkg;

  localparam int unsigned TIMER_CLOCK    = 275000000;
  localparam int unsigned PRESCALE_SHIFT = 16;
  localparam int unsigned PRESCALE_NUM   = TIMER_CLOCK >> PRESCALE_SHIFT;
  localparam int unsigned PERIOD_RESET   = 10741;
  localparam int unsigned RATE_RESET     = 12800;

  localparam int unsigned RATE_W = 20;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned QUO_W  = 32;
  localparam int unsigned DEN_W  = RATE_W + 1;
  localparam int unsigned STEP_W = 5;
  localparam int unsigned OUT_W  = 4;

  localparam logic [1:0] KIND_CLOCK  = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_INIT   = 2'd2;

  typedef logic signed [POS_W-1:0] pos_t;

endpackage

// File: hdl/multi_axis_step_dir_generator.sv
// Multi-axis step/direction generator: timer prescaler/period, per-motor sequencing.
// Depends on msdg_pkg.
// An item is taken in S_IDLE and run in S_EXEC; on a timer overflow S_TICK then visits
// the motors one a cycle through the shared 33-bit subtractor. S_DONE registers the
// result once the output is free; no new item is taken until the block returns to S_IDLE.
// A step rate write busies the block for three 32-step restoring divisions.
// Reset (synchronous, rst_n low) clears counters, positions, targets, levels and enables.
module multi_axis_step_dir_generator
  import msdg_pkg::*;
#(
  parameter int MOTORS       = 4,
  parameter int COUNTER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [RATE_W-1:0]   cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [1:0]          in_motor_index,
  input  logic signed [31:0]  in_target_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_W-1:0]    out_step_levels,
  output logic [OUT_W-1:0]    out_dir_levels,
  output logic [OUT_W-1:0]    out_reached_mask,
  output logic                out_tick_fired
);

  localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int IW     = (MIDX_W > 2) ? MIDX_W : 2;
  localparam logic [MIDX_W-1:0] LAST_MOTOR = MIDX_W'(MOTORS - 1);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_TICK, S_DONE, S_DIV} state_t;
  typedef enum logic [1:0] {PH_PRE, PH_PER_A, PH_PER_B} phase_t;

  state_t                    state_r;
  phase_t                    phase_r;
  logic [RATE_W-1:0]         rate_r;
  logic [COUNTER_BITS-1:0]   psc_val_r, per_val_r, psc_cnt_r, per_cnt_r;
  pos_t                      pos_r [MOTORS];
  pos_t                      tgt_r [MOTORS];
  logic [MOTORS-1:0]         step_r, dir_r, en_r, reached_r;
  logic [MIDX_W-1:0]         mcnt_r;
  logic [1:0]                kind_r;
  logic                      idx_ok_r;
  logic [MIDX_W-1:0]         idx_r;
  pos_t                      tv_r;
  logic                      fired_r;
  logic                      out_valid_r;
  logic [OUT_W-1:0]          out_step_r, out_dir_r, out_reached_r;
  logic                      out_fired_r;
  logic [QUO_W-1:0]          quo_r;
  logic [DEN_W-1:0]          rem_r, den_r;
  logic [STEP_W-1:0]         dcnt_r;

  logic [IW-1:0]             idx_ext;
  logic [MIDX_W-1:0]         addr;
  pos_t                      op_a, pos_rd, tgt_rd;
  logic signed [POS_W:0]     diff;
  logic                      eq, up, near;
  logic                      tick_wrap;
  logic [DEN_W:0]            trial;
  logic                      ge;
  logic [DEN_W-1:0]          rem_nxt;
  logic [QUO_W-1:0]          quo_nxt;
  logic [QUO_W:0]            half_sum;
  logic [MOTORS+OUT_W-1:0]   step_pad, dir_pad, reached_pad;

  assign idx_ext = IW'(in_motor_index);
  assign addr    = (state_r == S_TICK) ? mcnt_r : idx_r;
  assign pos_rd  = pos_r[addr];
  assign tgt_rd  = tgt_r[addr];
  assign op_a    = (state_r == S_EXEC) ? tv_r : tgt_rd;
  assign diff    = {op_a[POS_W-1], op_a} - {pos_rd[POS_W-1], pos_rd};
  assign eq      = (diff == '0);
  assign up      = !diff[POS_W] && !eq;
  assign near    = (diff == (POS_W+1)'(1)) || (diff == '1);

  assign tick_wrap = (kind_r == KIND_CLOCK) && (psc_cnt_r >= psc_val_r) &&
                     (per_cnt_r >= per_val_r);

  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign ge       = (trial >= {1'b0, den_r});
  assign rem_nxt  = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
  assign quo_nxt  = {quo_r[QUO_W-2:0], ge};
  assign half_sum = ((QUO_W+1)'(quo_nxt) + (QUO_W+1)'(rate_r)) >> 1;

  assign step_pad    = {{OUT_W{1'b0}}, step_r};
  assign dir_pad     = {{OUT_W{1'b0}}, dir_r};
  assign reached_pad = {{OUT_W{1'b0}}, reached_r};

  assign in_ready         = (state_r == S_IDLE) && !cfg_wr_en;
  assign out_valid        = out_valid_r;
  assign out_step_levels  = out_step_r;
  assign out_dir_levels   = out_dir_r;
  assign out_reached_mask = out_reached_r;
  assign out_tick_fired   = out_fired_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_PRE;
      rate_r      <= RATE_W'(RATE_RESET);
      psc_val_r   <= '0;
      per_val_r   <= COUNTER_BITS'(PERIOD_RESET);
      psc_cnt_r   <= '0;
      per_cnt_r   <= '0;
      step_r      <= '0;
      dir_r       <= '0;
      en_r        <= '0;
      reached_r   <= '1;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MOTORS; i++) begin
        pos_r[i] <= '0;
        tgt_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready && (cfg_wr_en || state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        rate_r    <= (cfg_wr_data == '0) ? RATE_W'(1) : cfg_wr_data;
        den_r     <= (cfg_wr_data == '0) ? DEN_W'(1) : DEN_W'(cfg_wr_data);
        quo_r     <= QUO_W'(PRESCALE_NUM);
        rem_r     <= '0;
        dcnt_r    <= '0;
        phase_r   <= PH_PRE;
        psc_cnt_r <= '0;
        per_cnt_r <= '0;
        state_r   <= S_DIV;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_valid) begin
              kind_r   <= in_kind;
              idx_ok_r <= (32'(idx_ext) < MOTORS);
              idx_r    <= idx_ext[MIDX_W-1:0];
              tv_r     <= in_target_value;
              state_r  <= S_EXEC;
            end
          end
          S_EXEC: begin
            fired_r <= tick_wrap;
            mcnt_r  <= '0;
            state_r <= tick_wrap ? S_TICK : S_DONE;
            case (kind_r)
              KIND_CLOCK: begin
                if (psc_cnt_r < psc_val_r) begin
                  psc_cnt_r <= psc_cnt_r + 1'b1;
                end else begin
                  psc_cnt_r <= '0;
                  if (per_cnt_r < per_val_r) begin
                    per_cnt_r <= per_cnt_r + 1'b1;
                  end else begin
                    per_cnt_r <= '0;
                  end
                end
              end
              KIND_TARGET: begin
                if (idx_ok_r) begin
                  tgt_r[idx_r]     <= tv_r;
                  reached_r[idx_r] <= eq;
                end
              end
              KIND_INIT: begin
                if (idx_ok_r) begin
                  pos_r[idx_r]     <= '0;
                  tgt_r[idx_r]     <= '0;
                  step_r[idx_r]    <= 1'b0;
                  dir_r[idx_r]     <= 1'b0;
                  en_r[idx_r]      <= 1'b1;
                  reached_r[idx_r] <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
          S_TICK: begin
            if (en_r[addr] && !eq) begin
              if (dir_r[addr] != up) begin
                dir_r[addr] <= up;
              end else begin
                step_r[addr]    <= ~step_r[addr];
                pos_r[addr]     <= up ? pos_rd + 1 : pos_rd - 1;
                reached_r[addr] <= near;
              end
            end
            if (mcnt_r == LAST_MOTOR) begin
              state_r <= S_DONE;
            end else begin
              mcnt_r <= mcnt_r + 1'b1;
            end
          end
          S_DONE: begin
            if (!out_valid_r || out_ready) begin
              out_valid_r   <= 1'b1;
              out_step_r    <= step_pad[OUT_W-1:0];
              out_dir_r     <= dir_pad[OUT_W-1:0];
              out_reached_r <= reached_pad[OUT_W-1:0];
              out_fired_r   <= fired_r;
              state_r       <= S_IDLE;
            end
          end
          S_DIV: begin
            dcnt_r <= dcnt_r + 1'b1;
            if (dcnt_r != '1) begin
              rem_r <= rem_nxt;
              quo_r <= quo_nxt;
            end else begin
              rem_r <= '0;
              unique case (phase_r)
                PH_PRE: begin
                  psc_val_r <= COUNTER_BITS'(quo_nxt);
                  quo_r     <= QUO_W'(TIMER_CLOCK);
                  den_r     <= DEN_W'(quo_nxt) + DEN_W'(1);
                  phase_r   <= PH_PER_A;
                end
                PH_PER_A: begin
                  quo_r   <= half_sum[QUO_W-1:0];
                  den_r   <= DEN_W'(rate_r);
                  phase_r <= PH_PER_B;
                end
                PH_PER_B: begin
                  per_val_r <= COUNTER_BITS'(quo_nxt - QUO_W'(1));
                  phase_r   <= PH_PRE;
                  state_r   <= S_IDLE;
                end
                default: begin
                  state_r <= S_IDLE;
                end
              endcase
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_ready)
    else $error("ready while deriving timing");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !cfg_wr_en) |=> !in_ready)
    else $error("second beat taken during item");

  a_div_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (psc_cnt_r == '0 && per_cnt_r == '0))
    else $error("timer counters not cleared during derivation");

  a_tick_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK) |-> (psc_cnt_r == '0 && per_cnt_r == '0 && fired_r))
    else $error("motor sweep without overflow");

endmodule
